// ----- src/agc_pkg.sv -----
// Package for the accelerometer gesture classifier: field widths, register
// indexes, reset values, gesture codes and the CORDIC arctangent table.
// No dependencies.
package agc_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned ATAN_TAB_DEPTH   = 24;

  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned IN_DATA_W   = 80;
  localparam int unsigned OUT_DATA_W  = 56;

  localparam logic [CFG_IDX_W-1:0] REG_SHAKE_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FACE_LIMIT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN    = 2'd3;

  localparam logic [15:0] SHAKE_LIMIT_RST = 16'd25053;
  localparam logic [7:0]  TILT_LIMIT_RST  = 8'd20;
  localparam logic [14:0] FACE_LIMIT_RST  = 15'd13361;
  localparam logic [15:0] COOLDOWN_RST    = 16'd300;

  localparam logic signed [15:0] GRAV_X_RST = 16'sd0;
  localparam logic signed [15:0] GRAV_Y_RST = 16'sd0;
  localparam logic signed [15:0] GRAV_Z_RST = 16'sd16384;

  localparam int unsigned CX_W = 28;
  localparam int unsigned CZ_W = 26;
  localparam logic signed [CZ_W-1:0] DEG90_Q16   = 26'sd5898240;
  localparam logic signed [CZ_W-1:0] ROUND_Q9_7  = 26'sd256;

  typedef enum logic [2:0] {
    GEST_NONE       = 3'd0,
    GEST_SHAKE      = 3'd1,
    GEST_TILT_BACK  = 3'd2,
    GEST_TILT_FWD   = 3'd3,
    GEST_RIGHT      = 3'd4,
    GEST_LEFT       = 3'd5,
    GEST_FACE_UP    = 3'd6,
    GEST_FACE_DOWN  = 3'd7
  } gesture_e;

  function automatic logic [21:0] atan_q16(logic [4:0] idx);
    logic [21:0] val;
    unique case (idx)
      5'd0:    val = 22'd2949120;
      5'd1:    val = 22'd1740967;
      5'd2:    val = 22'd919879;
      5'd3:    val = 22'd466945;
      5'd4:    val = 22'd234379;
      5'd5:    val = 22'd117304;
      5'd6:    val = 22'd58666;
      5'd7:    val = 22'd29335;
      5'd8:    val = 22'd14668;
      5'd9:    val = 22'd7334;
      5'd10:   val = 22'd3667;
      5'd11:   val = 22'd1833;
      5'd12:   val = 22'd917;
      5'd13:   val = 22'd458;
      5'd14:   val = 22'd229;
      5'd15:   val = 22'd115;
      5'd16:   val = 22'd57;
      5'd17:   val = 22'd29;
      5'd18:   val = 22'd14;
      5'd19:   val = 22'd7;
      5'd20:   val = 22'd4;
      5'd21:   val = 22'd2;
      5'd22:   val = 22'd1;
      default: val = 22'd0;
    endcase
    return val;
  endfunction

endpackage

// ----- src/accel_gesture_classifier_top.sv -----
// Accelerometer gesture classifier on one sequenced datapath. Depends on agc_pkg.
// A tick in cooldown or with a failed read goes straight to the result; a shake passes
// the squarer and shake compare; otherwise it passes the squarer, shake compare, root
// loop, two CORDIC passes and decide, then waits until the output register is free.
// s_axis_tready_o is high only while idle, so a new tick is taken only once the last is done.
// Reset: registers at reset values, gravity (0, 0, 16384), last time 0.
module accel_gesture_classifier_top
  import agc_pkg::*;
#(
  parameter int unsigned CordicSteps = CORDIC_STEPS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // now_ms[31:0], accel_x[47:32], accel_y[63:48], accel_z[79:64]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // sample_ok[0]
  input  logic                  s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // gesture[2:0], gravity_x[18:3], gravity_y[34:19], gravity_z[50:35], zero[55:51]
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  localparam int unsigned StepW = $clog2(CordicSteps + 1);
  localparam logic [StepW-1:0] LastStep = StepW'(CordicSteps - 1);
  localparam logic [StepW-1:0] MulLast  = StepW'(4);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MUL   = 9'b000000010,
    S_SHK   = 9'b000000100,
    S_ISQ   = 9'b000001000,
    S_CSET  = 9'b000010000,
    S_CITER = 9'b000100000,
    S_CEND  = 9'b001000000,
    S_DEC   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic             pass_q, pass_d;
  logic             out_valid_q, out_valid_d;

  logic [15:0] shake_q, shake_d;
  logic [7:0]  tilt_q, tilt_d;
  logic [14:0] face_q, face_d;
  logic [15:0] cool_q, cool_d;
  logic [31:0] last_q, last_d;
  logic signed [15:0] gx_q, gx_d, gy_q, gy_d, gz_q, gz_d;

  logic signed [33:0] prod_q, prod_d;
  logic [31:0] yz_q, yz_d, mag_q, mag_d, lim_q, lim_d;
  logic [31:0] isq_v_q, isq_v_d, isq_r_q, isq_r_d, isq_b_q, isq_b_d;
  logic signed [CX_W-1:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [CZ_W-1:0] cz_q, cz_d;
  logic zero_q, zero_d;
  logic signed [15:0] roll_q, roll_d, pitch_q, pitch_d;
  gesture_e res_q, res_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  logic [31:0] in_now;
  logic signed [15:0] in_x, in_y, in_z;
  logic        in_fire, out_fire, cool_pass;
  logic signed [16:0] mul_op;
  logic [32:0] isq_sum;
  logic signed [16:0] c_ya, c_xa;
  logic signed [CX_W-1:0] c_xs, c_ys, c_dx, c_dy;
  logic signed [CZ_W-1:0] c_atan, c_round;
  logic signed [15:0] c_angle;
  logic signed [16:0] tilt_t, pitch_e, roll_e, z_e, face_e;

  assign in_now = s_axis_tdata_i[31:0];
  assign in_x   = s_axis_tdata_i[47:32];
  assign in_y   = s_axis_tdata_i[63:48];
  assign in_z   = s_axis_tdata_i[79:64];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire  = out_valid_q && m_axis_tready_i;
  assign cool_pass = (in_now - last_q) >= {16'd0, cool_q};

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  always_comb begin
    unique case (step_q[1:0])
      2'd0:    mul_op = {gy_q[15], gy_q};
      2'd1:    mul_op = {gz_q[15], gz_q};
      2'd2:    mul_op = {gx_q[15], gx_q};
      default: mul_op = {1'b0, shake_q};
    endcase
  end

  assign isq_sum = {1'b0, isq_r_q} + {1'b0, isq_b_q};

  assign c_ya = pass_q ? -{gx_q[15], gx_q} : {gy_q[15], gy_q};
  assign c_xa = pass_q ? {1'b0, isq_r_q[15:0]} : {gz_q[15], gz_q};
  assign c_xs = CX_W'(c_xa) <<< 8;
  assign c_ys = CX_W'(c_ya) <<< 8;
  assign c_dx = cy_q >>> step_q;
  assign c_dy = cx_q >>> step_q;
  assign c_atan  = CZ_W'(atan_q16(5'(step_q)));
  assign c_round = (cz_q + ROUND_Q9_7) >>> 9;
  assign c_angle = zero_q ? 16'sd0 : c_round[15:0];

  assign tilt_t  = {2'b00, tilt_q, 7'd0};
  assign pitch_e = {pitch_q[15], pitch_q};
  assign roll_e  = {roll_q[15], roll_q};
  assign z_e     = {gz_q[15], gz_q};
  assign face_e  = {2'b00, face_q};

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    pass_d      = pass_q;
    out_valid_d = out_valid_q;
    shake_d     = shake_q;
    tilt_d      = tilt_q;
    face_d      = face_q;
    cool_d      = cool_q;
    last_d      = last_q;
    gx_d        = gx_q;
    gy_d        = gy_q;
    gz_d        = gz_q;
    prod_d      = prod_q;
    yz_d        = yz_q;
    mag_d       = mag_q;
    lim_d       = lim_q;
    isq_v_d     = isq_v_q;
    isq_r_d     = isq_r_q;
    isq_b_d     = isq_b_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    cz_d        = cz_q;
    zero_d      = zero_q;
    roll_d      = roll_q;
    pitch_d     = pitch_q;
    res_d       = res_q;
    out_data_d  = out_data_q;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SHAKE_LIMIT: shake_d = cfg_wdata_i;
        REG_TILT_LIMIT:  tilt_d  = cfg_wdata_i[7:0];
        REG_FACE_LIMIT:  face_d  = cfg_wdata_i[14:0];
        REG_COOLDOWN:    cool_d  = cfg_wdata_i;
        default:         ;
      endcase
    end

    if (out_fire) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          res_d = GEST_NONE;
          step_d = '0;
          pass_d = 1'b0;
          if (cool_pass) begin
            last_d = in_now;
          end
          if (cool_pass && s_axis_tuser_i) begin
            gx_d = in_x;
            gy_d = in_y;
            gz_d = in_z;
            state_d = S_MUL;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_MUL: begin
        prod_d = 34'(mul_op) * 34'(mul_op);
        unique case (step_q[2:0])
          3'd1:    yz_d  = prod_q[31:0];
          3'd2:    yz_d  = yz_q + prod_q[31:0];
          3'd3:    mag_d = yz_q + prod_q[31:0];
          3'd4:    lim_d = prod_q[31:0];
          default: ;
        endcase
        if (step_q == MulLast) begin
          step_d  = '0;
          state_d = S_SHK;
        end else begin
          step_d = step_q + StepW'(1);
        end
      end
      S_SHK: begin
        if (mag_q > lim_q) begin
          res_d   = GEST_SHAKE;
          state_d = S_DONE;
        end else begin
          isq_v_d = yz_q;
          isq_r_d = '0;
          isq_b_d = 32'h4000_0000;
          state_d = S_ISQ;
        end
      end
      S_ISQ: begin
        if ({1'b0, isq_v_q} >= isq_sum) begin
          isq_v_d = isq_v_q - isq_sum[31:0];
          isq_r_d = (isq_r_q >> 1) + isq_b_q;
        end else begin
          isq_r_d = isq_r_q >> 1;
        end
        isq_b_d = isq_b_q >> 2;
        if (isq_b_q == 32'd1) begin
          state_d = S_CSET;
        end
      end
      S_CSET: begin
        zero_d = (c_xa == 17'sd0) && (c_ya == 17'sd0);
        step_d = '0;
        if (c_xs < 0) begin
          if (c_ys >= 0) begin
            cx_d = c_ys;
            cy_d = -c_xs;
            cz_d = DEG90_Q16;
          end else begin
            cx_d = -c_ys;
            cy_d = c_xs;
            cz_d = -DEG90_Q16;
          end
        end else begin
          cx_d = c_xs;
          cy_d = c_ys;
          cz_d = '0;
        end
        state_d = S_CITER;
      end
      S_CITER: begin
        if (cy_q >= 0) begin
          cx_d = cx_q + c_dx;
          cy_d = cy_q - c_dy;
          cz_d = cz_q + c_atan;
        end else begin
          cx_d = cx_q - c_dx;
          cy_d = cy_q + c_dy;
          cz_d = cz_q - c_atan;
        end
        if (step_q == LastStep) begin
          state_d = S_CEND;
        end else begin
          step_d = step_q + StepW'(1);
        end
      end
      S_CEND: begin
        if (pass_q) begin
          pitch_d = c_angle;
          state_d = S_DEC;
        end else begin
          roll_d  = c_angle;
          pass_d  = 1'b1;
          state_d = S_CSET;
        end
      end
      S_DEC: begin
        priority if (pitch_e > tilt_t)  res_d = GEST_TILT_BACK;
        else if (pitch_e < -tilt_t)     res_d = GEST_TILT_FWD;
        else if (roll_e > tilt_t)       res_d = GEST_RIGHT;
        else if (roll_e < -tilt_t)      res_d = GEST_LEFT;
        else if (z_e > face_e)          res_d = GEST_FACE_UP;
        else if (z_e < -face_e)         res_d = GEST_FACE_DOWN;
        else                            res_d = GEST_NONE;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = {5'd0, gz_q, gy_q, gx_q, res_q};
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      pass_q      <= 1'b0;
      out_valid_q <= 1'b0;
      shake_q     <= SHAKE_LIMIT_RST;
      tilt_q      <= TILT_LIMIT_RST;
      face_q      <= FACE_LIMIT_RST;
      cool_q      <= COOLDOWN_RST;
      last_q      <= '0;
      gx_q        <= GRAV_X_RST;
      gy_q        <= GRAV_Y_RST;
      gz_q        <= GRAV_Z_RST;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
      shake_q     <= shake_d;
      tilt_q      <= tilt_d;
      face_q      <= face_d;
      cool_q      <= cool_d;
      last_q      <= last_d;
      gx_q        <= gx_d;
      gy_q        <= gy_d;
      gz_q        <= gz_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q     <= prod_d;
    yz_q       <= yz_d;
    mag_q      <= mag_d;
    lim_q      <= lim_d;
    isq_v_q    <= isq_v_d;
    isq_r_q    <= isq_r_d;
    isq_b_q    <= isq_b_d;
    cx_q       <= cx_d;
    cy_q       <= cy_d;
    cz_q       <= cz_d;
    zero_q     <= zero_d;
    roll_q     <= roll_d;
    pitch_q    <= pitch_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

endmodule

// ----- src/agc_checker.sv -----
// Port-level checks for the gesture classifier, bound to the top level.
// Depends on agc_pkg and accel_gesture_classifier_top.
module agc_checker
  import agc_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_we_i,
  input logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input logic                  s_axis_tuser_i,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> (!m_axis_tvalid_o && s_axis_tready_o))
    else $error("result valid or input blocked during reset");

  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input taken again while a tick is in work");

  a_face_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      ((m_axis_tdata_o[2:0] != GEST_FACE_UP ||
        $signed(m_axis_tdata_o[50:35]) > 16'sd0) &&
       (m_axis_tdata_o[2:0] != GEST_FACE_DOWN ||
        $signed(m_axis_tdata_o[50:35]) < 16'sd0)))
    else $error("face code disagrees with sign of gravity z");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result beat changed");

endmodule

bind accel_gesture_classifier_top agc_checker u_agc_checker (.*);
